// File: hw/rtl/sequential_list_engine_macros.svh
// Assertion macros used by the list engine module.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Checks an implication on every rising edge outside reset.
`define SLE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sle assertion failed");

// Checks that the consequent holds in the cycle after the antecedent, on every rising edge outside reset.
`define SLE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sle assertion failed");

`endif

// File: hw/rtl/sle_pkg.sv
`default_nettype none
package sle_pkg;
    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 7;
    localparam int KIND_W     = 3;

    localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] K_DELAT  = 3'd2;
    localparam logic [KIND_W-1:0] K_DELVAL = 3'd3;
    localparam logic [KIND_W-1:0] K_SORT   = 3'd4;
    localparam logic [KIND_W-1:0] K_LSRCH  = 3'd5;
    localparam logic [KIND_W-1:0] K_BSRCH  = 3'd6;
    localparam logic [KIND_W-1:0] K_DUMP   = 3'd7;

    typedef logic [DATA_WIDTH-1:0] t_word;
endpackage
`default_nettype wire

// File: hw/rtl/sle_mem.sv
`default_nettype none
module sle_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/sequential_list_engine.sv
// The engine keeps a packed list of up to 32 unsigned 32-bit words and runs one
// operation per input word, during which it stalls its input. Every operation
// gives one result word except dump, which gives one per entry, or one status
// word when the list is empty. All work goes through a list memory with one
// write port and a registered read port, and one shared comparator, so each
// element read costs a read state and then a compare, write or output state.
// No clearing pass follows reset; the count alone marks the valid entries.
`default_nettype none
`include "sequential_list_engine_macros.svh"
module sequential_list_engine
    import sle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [POS_W-1:0]      i_position,
    input  wire logic [31:0]           i_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_status,
    output logic [31:0]                o_data,
    output logic [CNT_W-1:0]           o_count,
    output logic                       o_last
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_DEL_RD  = 4'd3;
    localparam logic [3:0] S_DEL_WR  = 4'd4;
    localparam logic [3:0] S_SCN_RD  = 4'd5;
    localparam logic [3:0] S_SCN_CMP = 4'd6;
    localparam logic [3:0] S_SRT_I   = 4'd7;
    localparam logic [3:0] S_SRT_LD  = 4'd8;
    localparam logic [3:0] S_SRT_RD  = 4'd9;
    localparam logic [3:0] S_SRT_CMP = 4'd10;
    localparam logic [3:0] S_BIN_RD  = 4'd11;
    localparam logic [3:0] S_BIN_CMP = 4'd12;
    localparam logic [3:0] S_DMP_RD  = 4'd13;
    localparam logic [3:0] S_DMP_OUT = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]        r_j, n_j;
    logic [CNT_W-1:0]        r_p, n_p;
    logic signed [CNT_W:0]   r_lo, n_lo;
    logic signed [CNT_W:0]   r_hi, n_hi;
    logic [KIND_W-1:0]       r_kind, n_kind;
    t_word                   r_val, n_val;
    t_word                   r_hold, n_hold;
    logic                    r_ok, n_ok;
    logic                    r_ovalid, n_ovalid;
    logic                    r_ostatus, n_ostatus;
    t_word                   r_odata, n_odata;
    logic [CNT_W-1:0]        r_ocount, n_ocount;
    logic                    r_olast, n_olast;

    logic                    we, re;
    logic [ADDR_W-1:0]       waddr, raddr;
    t_word                   wdata, rdata;
    t_word                   cmp_a, cmp_b;
    logic                    cmp_eq, cmp_gt;
    logic                    accept, out_free;
    logic [POS_W-1:0]        cnt_ext;
    logic signed [CNT_W:0]   bin_sum;
    logic [CNT_W-1:0]        bin_mid;

    sle_mem #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign cnt_ext  = POS_W'(r_count);
    assign bin_sum  = r_lo + r_hi;
    assign bin_mid  = CNT_W'(bin_sum[CNT_W:1]);

    // The one comparator, shared by the searches and the sort.
    always_comb begin
        cmp_a = rdata;
        cmp_b = r_val;
        if (r_state == S_SRT_CMP) begin
            cmp_a = r_hold;
            cmp_b = rdata;
        end
    end
    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_gt = (cmp_a > cmp_b);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_p       = r_p;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_kind    = r_kind;
        n_val     = r_val;
        n_hold    = r_hold;
        n_ok      = r_ok;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_odata   = r_odata;
        n_ocount  = r_ocount;
        n_olast   = r_olast;
        we        = 1'b0;
        re        = 1'b0;
        waddr     = r_j[ADDR_W-1:0];
        raddr     = r_j[ADDR_W-1:0];
        wdata     = rdata;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_kind;
                    n_val  = t_word'(i_value);
                    n_ok   = 1'b0;
                    n_j    = '0;
                    n_state = S_DONE;
                    unique case (i_kind) inside
                        K_APPEND: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                we      = 1'b1;
                                waddr   = r_count[ADDR_W-1:0];
                                wdata   = t_word'(i_value);
                                n_count = r_count + 1'b1;
                                n_ok    = 1'b1;
                            end
                        end
                        K_INSERT: begin
                            if (i_position >= POS_W'(1) && i_position <= cnt_ext + 1'b1
                                && r_count < CNT_W'(CAPACITY)) begin
                                n_j     = r_count;
                                n_p     = CNT_W'(i_position - 1'b1);
                                n_state = S_INS_RD;
                            end
                        end
                        K_DELAT: begin
                            if (i_position >= POS_W'(1) && i_position <= cnt_ext) begin
                                n_j     = CNT_W'(i_position - 1'b1);
                                n_state = S_DEL_RD;
                            end
                        end
                        K_DELVAL, K_LSRCH: n_state = S_SCN_RD;
                        K_SORT: begin
                            n_i     = '0;
                            n_state = S_SRT_I;
                        end
                        K_BSRCH: begin
                            n_lo    = '0;
                            n_hi    = $signed({1'b0, r_count}) - 2'sd1;
                            n_state = S_BIN_RD;
                        end
                        default: begin
                            if (r_count != '0) begin
                                n_state = S_DMP_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_j > r_p) begin
                    re      = 1'b1;
                    raddr   = ADDR_W'(r_j - 1'b1);
                    n_state = S_INS_WR;
                end else begin
                    we      = 1'b1;
                    waddr   = r_p[ADDR_W-1:0];
                    wdata   = r_val;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_INS_WR: begin
                we      = 1'b1;
                n_j     = r_j - 1'b1;
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                if (r_j + 1'b1 < r_count) begin
                    re      = 1'b1;
                    raddr   = ADDR_W'(r_j + 1'b1);
                    n_state = S_DEL_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DEL_WR: begin
                we      = 1'b1;
                n_j     = r_j + 1'b1;
                n_state = S_DEL_RD;
            end
            S_SCN_RD: begin
                if (r_j < r_count) begin
                    re      = 1'b1;
                    n_state = S_SCN_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCN_CMP: begin
                if (cmp_eq) begin
                    if (r_kind == K_DELVAL) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCN_RD;
                end
            end
            S_SRT_I: begin
                if (r_i < r_count) begin
                    re      = 1'b1;
                    raddr   = r_i[ADDR_W-1:0];
                    n_state = S_SRT_LD;
                end else begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SRT_LD: begin
                n_hold  = rdata;
                n_j     = r_i + 1'b1;
                n_state = S_SRT_RD;
            end
            S_SRT_RD: begin
                if (r_j < r_count) begin
                    re      = 1'b1;
                    n_state = S_SRT_CMP;
                end else begin
                    we      = 1'b1;
                    waddr   = r_i[ADDR_W-1:0];
                    wdata   = r_hold;
                    n_i     = r_i + 1'b1;
                    n_state = S_SRT_I;
                end
            end
            S_SRT_CMP: begin
                if (cmp_gt) begin
                    we     = 1'b1;
                    wdata  = r_hold;
                    n_hold = rdata;
                end
                n_j     = r_j + 1'b1;
                n_state = S_SRT_RD;
            end
            S_BIN_RD: begin
                if (r_lo <= r_hi) begin
                    re      = 1'b1;
                    raddr   = bin_mid[ADDR_W-1:0];
                    n_j     = bin_mid;
                    n_state = S_BIN_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BIN_CMP: begin
                n_state = S_BIN_RD;
                if (cmp_gt) begin
                    n_hi = $signed({1'b0, r_j}) - 2'sd1;
                end else if (!cmp_eq) begin
                    n_lo = $signed({1'b0, r_j}) + 2'sd1;
                end else begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DMP_RD: begin
                re      = 1'b1;
                n_state = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = 1'b1;
                    n_odata   = rdata;
                    n_ocount  = r_count;
                    n_olast   = (r_j + 1'b1 == r_count);
                    n_j       = r_j + 1'b1;
                    n_state   = (r_j + 1'b1 == r_count) ? S_IDLE : S_DMP_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_ok;
                    n_odata   = '0;
                    n_ocount  = r_count;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_p       <= n_p;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_kind    <= n_kind;
        r_val     <= n_val;
        r_hold    <= n_hold;
        r_ok      <= n_ok;
        r_ostatus <= n_ostatus;
        r_odata   <= n_odata;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_data   = 32'(r_odata);
    assign o_count  = r_ocount;
    assign o_last   = r_olast;

    `SLE_ASSERT_IMP(a_count_cap, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SLE_ASSERT_NXT(a_accept_busy, accept, r_state != S_IDLE)
    `SLE_ASSERT_NXT(a_count_step, r_state != S_IDLE,
        r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
        || r_count == $past(r_count) - 1'b1)
    `SLE_ASSERT_IMP(a_dump_data, o_valid && !o_status, o_data == '0)
endmodule
`default_nettype wire

// File: test/tb_sequential_list_engine.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_sequential_list_engine;
    import sle_pkg::*;

    class list_scoreboard;
        logic [31:0] entries[$];
        logic [31:0] due_data[$];
        logic        due_status[$];
        logic [5:0]  due_count[$];
        logic        due_last[$];
        int          errors;
        int          words_checked;

        function void push_result(logic st, logic [31:0] d, logic l);
            due_status.push_back(st);
            due_data.push_back(d);
            due_count.push_back(6'(entries.size()));
            due_last.push_back(l);
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, int pos, logic [31:0] v);
            int lo;
            int hi;
            int mid;
            logic ok;
            logic [31:0] t;
            ok = 1'b0;
            case (kind)
                K_APPEND: begin
                    if (entries.size() < CAPACITY) begin
                        entries.push_back(v);
                        ok = 1'b1;
                    end
                end
                K_INSERT: begin
                    if (pos >= 1 && pos <= entries.size() + 1 && entries.size() < CAPACITY) begin
                        entries.insert(pos - 1, v);
                        ok = 1'b1;
                    end
                end
                K_DELAT: begin
                    if (pos >= 1 && pos <= entries.size()) begin
                        entries.delete(pos - 1);
                        ok = 1'b1;
                    end
                end
                K_DELVAL: begin
                    for (int i = 0; i < entries.size(); i++) begin
                        if (entries[i] == v) begin
                            entries.delete(i);
                            ok = 1'b1;
                            break;
                        end
                    end
                end
                K_SORT: begin
                    for (int i = 0; i < entries.size(); i++) begin
                        for (int j = i + 1; j < entries.size(); j++) begin
                            if (entries[i] > entries[j]) begin
                                t = entries[i];
                                entries[i] = entries[j];
                                entries[j] = t;
                            end
                        end
                    end
                    ok = 1'b1;
                end
                K_LSRCH: begin
                    foreach (entries[i]) if (entries[i] == v) ok = 1'b1;
                end
                K_BSRCH: begin
                    lo = 0;
                    hi = entries.size() - 1;
                    while (lo <= hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (entries[mid] > v) hi = mid - 1;
                        else if (entries[mid] < v) lo = mid + 1;
                        else begin
                            ok = 1'b1;
                            break;
                        end
                    end
                end
                default: begin
                    if (entries.size() == 0) push_result(1'b0, '0, 1'b1);
                    foreach (entries[i])
                        push_result(1'b1, entries[i], i == entries.size() - 1);
                    return;
                end
            endcase
            push_result(ok, '0, 1'b1);
        endfunction

        function void check_result(logic st, logic [31:0] d, logic [5:0] c, logic l);
            words_checked++;
            if (due_data.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            if (st !== due_status[0]) begin
                $error("status: expected %0d, got %0d", due_status[0], st);
                errors++;
            end
            if (d !== due_data[0]) begin
                $error("data: expected %0h, got %0h", due_data[0], d);
                errors++;
            end
            if (c !== due_count[0]) begin
                $error("count: expected %0d, got %0d", due_count[0], c);
                errors++;
            end
            if (l !== due_last[0]) begin
                $error("last: expected %0d, got %0d", due_last[0], l);
                errors++;
            end
            void'(due_status.pop_front());
            void'(due_data.pop_front());
            void'(due_count.pop_front());
            void'(due_last.pop_front());
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind = '0;
    logic [POS_W-1:0]  i_position = '0;
    logic [31:0]       i_value = '0;
    logic              o_valid;
    logic              i_stall = 1'b1;
    logic              o_status;
    logic [31:0]       o_data;
    logic [CNT_W-1:0]  o_count;
    logic              o_last;

    list_scoreboard sb = new();
    int  ops_sent;
    int  burst_left;
    logic [31:0] recent[$];

    sequential_list_engine dut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver alternates between quiet spells and spells of random stalling.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_data, 6'(o_count), o_last);
        if (!i_rst_n) i_stall <= 1'b0;
        else if ((sb.words_checked / 64) % 2 == 1) i_stall <= ($urandom_range(0, 2) == 0);
        else i_stall <= 1'b0;
    end

    task automatic send_op(logic [KIND_W-1:0] kind, int pos, logic [31:0] v);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_position <= POS_W'(pos);
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, pos, v);
        ops_sent++;
        if (kind == K_APPEND || kind == K_INSERT) begin
            recent.push_back(v);
            if (recent.size() > 16) void'(recent.pop_front());
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2, 3: return (recent.size() != 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                              : $urandom();
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int n;
        int k;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(K_DUMP, 0, 0);
        send_op(K_SORT, 0, 0);
        send_op(K_BSRCH, 0, 5);
        send_op(K_DELAT, 1, 0);
        send_op(K_DELVAL, 0, 7);
        send_op(K_INSERT, 2, 1);
        send_op(K_INSERT, 1, 32'hFFFF_FFFF);
        send_op(K_APPEND, 0, 0);
        send_op(K_INSERT, 3, 32'h8000_0000);
        send_op(K_INSERT, 0, 3);
        send_op(K_INSERT, 127, 3);
        send_op(K_LSRCH, 0, 32'hFFFF_FFFF);
        send_op(K_BSRCH, 0, 0);
        send_op(K_SORT, 0, 0);
        send_op(K_BSRCH, 0, 32'h8000_0000);
        send_op(K_DUMP, 0, 0);
        send_op(K_DELAT, 4, 0);
        send_op(K_DELAT, 3, 0);
        send_op(K_DELVAL, 0, 0);
        send_op(K_DELVAL, 0, 12345);
        for (int i = 0; i < 32; i++) send_op(K_APPEND, 0, $urandom());
        send_op(K_APPEND, 0, 1);
        send_op(K_INSERT, 5, 1);
        send_op(K_DUMP, 0, 0);
        send_op(K_SORT, 0, 0);
        send_op(K_DELAT, 32, 0);

        n = 0;
        while (n < 293) begin
            k = $urandom_range(0, 19);
            if (k < 5) send_op(K_APPEND, 0, pick_value());
            else if (k < 8) send_op(K_INSERT, $urandom_range(0, sb.entries.size() + 2),
                                    pick_value());
            else if (k < 10) send_op(K_DELAT, ($urandom_range(0, 9) == 0) ?
                                     $urandom_range(0, 127) :
                                     $urandom_range(0, sb.entries.size() + 1), 0);
            else if (k < 12) send_op(K_DELVAL, 0, pick_value());
            else if (k < 13) send_op(K_SORT, $urandom_range(0, 127), $urandom());
            else if (k < 15) send_op(K_LSRCH, 0, pick_value());
            else if (k < 18) send_op(K_BSRCH, 0, pick_value());
            else send_op(K_DUMP, $urandom_range(0, 127), $urandom());
            n++;
        end
        i_valid <= 1'b0;

        wait (sb.due_data.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d operations and checked %0d result words.",
                 ops_sent, sb.words_checked);
        if (sb.errors == 0 && sb.due_data.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sle_pkg.sv
hw/rtl/sle_mem.sv
hw/rtl/sequential_list_engine.sv
test/tb_sequential_list_engine.sv
